/* src/assert_macros.svh */
// assertion macros used by the checker of this project
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// generic concurrent assertion on a given clock and active-low reset
`define SFR_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same, on the block clock and reset
`define SFR_ASSERT_CK(lbl, prop, msg) \
  `SFR_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

/* src/sfr_pkg.sv */
`timescale 1ns / 1ps

package sfr_pkg;

  // raw mode length prefix carries this offset
  localparam int unsigned SizeOffset = 4;
  localparam logic [7:0] SizeOffsetByte = 8'(SizeOffset);

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_ID      = 3'd1,
    ST_SIZE    = 3'd2,
    ST_DONE    = 3'd3,
    ST_NOSTOP  = 3'd4,
    ST_BADESC  = 3'd5,
    ST_NOSTART = 3'd6,
    ST_CHKERR  = 3'd7
  } sfr_status_e;

  typedef enum logic [2:0] {
    REG_START    = 3'd0,
    REG_STOP     = 3'd1,
    REG_ESCAPE   = 3'd2,
    REG_ESC_MASK = 3'd3,
    REG_MSG_MASK = 3'd4,
    REG_SIZE_MASK = 3'd5
  } sfr_reg_e;

  typedef enum logic {
    CMD_RECEIVE = 1'b0,
    CMD_RESTART = 1'b1
  } sfr_cmd_e;

  typedef struct packed {
    logic       command;
    logic [7:0] rx_byte;
  } sfr_in_t;

  typedef struct packed {
    logic [2:0] status;
    logic       data_valid;
    logic [7:0] data_byte;
    logic [7:0] packet_id;
    logic [7:0] packet_length;
  } sfr_out_t;

  typedef struct packed {
    logic [7:0] start_byte;
    logic [7:0] stop_byte;
    logic [7:0] escape_byte;
    logic [7:0] escape_mask;
    logic [7:0] id_message_mask;
    logic [7:0] id_size_mask;
  } sfr_cfg_t;

  typedef struct packed {
    logic       frame_done;
    logic       escape_pending;
    logic       flags_busy;
    logic       size_known;
    logic [7:0] ident;
    logic [7:0] raw_length;
    logic [7:0] byte_count;
    logic [7:0] running_sum;
    logic [7:0] held_byte;
    logic       held_valid;
  } sfr_state_t;

  localparam sfr_cfg_t CfgReset = '{
    start_byte:      8'd2,
    stop_byte:       8'd3,
    escape_byte:     8'd27,
    escape_mask:     8'd128,
    id_message_mask: 8'd128,
    id_size_mask:    8'd64
  };

  localparam sfr_state_t StateReset = '{
    frame_done:     1'b1,
    escape_pending: 1'b0,
    flags_busy:     1'b0,
    size_known:     1'b0,
    ident:          8'd0,
    raw_length:     8'd0,
    byte_count:     8'd0,
    running_sum:    8'd0,
    held_byte:      8'd0,
    held_valid:     1'b0
  };

endpackage

/* src/stuffed_frame_receiver_core.sv */
`timescale 1ns / 1ps

// Byte-stuffed frame receiver. Each request on the input channel carries one
// line byte (or a restart command) and yields exactly one result request with
// a status code, an optional released payload byte, the current packet id and,
// on completion, the payload length. Payload bytes come out one byte late, so
// the trailing checksum byte is never released. Throughput is one byte per
// clock when not stalled: the decode is a single pass of logic from the input
// port into the result register, and the only loop is the update of the
// receiver state. The result is valid in the cycle after the input is
// accepted. The input is ready whenever the result register is empty or
// being drained in the same cycle. Configuration writes are always ready and
// take effect at once; they are meant to be issued while the receiver is idle.
module stuffed_frame_receiver_core import sfr_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  // byte input channel
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  sfr_in_t    in_data_i,
  // result channel
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output sfr_out_t   out_data_o,
  // configuration write channel
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [2:0] cfg_index_i,
  input  logic [7:0] cfg_data_i
);

  sfr_cfg_t   cfg_q, cfg_d;
  sfr_state_t state_q, state_d;
  sfr_out_t   out_q, out_d;
  logic       out_valid_q, out_valid_d;
  sfr_out_t   step_res;
  logic       in_accept;

  // result register can take a new request when empty or draining
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_accept   = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // decode of one line byte against the current receiver state
  sfr_step u_step (
    .cfg_i    (cfg_q),
    .state_i  (state_q),
    .item_i   (in_data_i),
    .state_o  (state_d),
    .result_o (step_res)
  );

  // register file write decode; unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_START:     cfg_d.start_byte      = cfg_data_i;
        REG_STOP:      cfg_d.stop_byte       = cfg_data_i;
        REG_ESCAPE:    cfg_d.escape_byte     = cfg_data_i;
        REG_ESC_MASK:  cfg_d.escape_mask     = cfg_data_i;
        REG_MSG_MASK:  cfg_d.id_message_mask = cfg_data_i;
        REG_SIZE_MASK: cfg_d.id_size_mask    = cfg_data_i;
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  // result register: load on accept, clear valid once taken
  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (in_accept) begin
      out_d       = step_res;
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q       <= CfgReset;
      state_q     <= StateReset;
      out_valid_q <= 1'b0;
    end else begin
      cfg_q       <= cfg_d;
      out_valid_q <= out_valid_d;
      if (in_accept) begin
        state_q <= state_d;
      end
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/sfr_step.sv */
`timescale 1ns / 1ps

// next-state and result logic for one received byte
module sfr_step import sfr_pkg::*; (
  input  sfr_cfg_t   cfg_i,
  input  sfr_state_t state_i,
  input  sfr_in_t    item_i,
  output sfr_state_t state_o,
  output sfr_out_t   result_o
);

  logic [7:0] b;
  logic       held_is_flag;
  logic [7:0] held_add;
  logic [7:0] sum_pushed;
  logic       raw_mode;
  logic [7:0] decoded;

  assign b            = item_i.rx_byte;
  assign held_is_flag = (state_i.held_byte == cfg_i.start_byte) ||
                        (state_i.held_byte == cfg_i.stop_byte) ||
                        (state_i.held_byte == cfg_i.escape_byte);
  assign held_add     = held_is_flag ? (state_i.held_byte & ~cfg_i.escape_mask)
                                     : state_i.held_byte;
  assign sum_pushed   = state_i.held_valid ? (state_i.running_sum + held_add)
                                           : state_i.running_sum;
  assign raw_mode     = !state_i.frame_done &&
                        ((state_i.ident & cfg_i.id_message_mask) == 8'd0) &&
                        ((state_i.ident & cfg_i.id_size_mask) != 8'd0) &&
                        (state_i.byte_count < state_i.raw_length);
  assign decoded      = state_i.escape_pending ? (b | cfg_i.escape_mask) : b;

  always_comb begin
    state_o  = state_i;
    result_o = '0;
    result_o.status = ST_NONE;

    if (item_i.command == CMD_RESTART) begin
      state_o = StateReset;
    end else if (raw_mode) begin
      if (state_i.size_known) begin
        // raw byte: release held, hold this one
        result_o.data_valid = state_i.held_valid;
        result_o.data_byte  = state_i.held_valid ? state_i.held_byte : 8'd0;
        state_o.running_sum = sum_pushed;
        state_o.held_byte   = b;
        state_o.held_valid  = 1'b1;
        state_o.byte_count  = state_i.byte_count + 8'd1;
      end else begin
        state_o.raw_length = b - SizeOffsetByte;
        state_o.size_known = 1'b1;
        result_o.status    = ST_SIZE;
      end
    end else if (b == cfg_i.start_byte) begin
      if (!state_i.frame_done) begin
        result_o.status = ST_NOSTOP;
      end
      state_o            = StateReset;
      state_o.raw_length = 8'd1;
      state_o.frame_done = 1'b0;
    end else if (b == cfg_i.escape_byte) begin
      if (state_i.frame_done || state_i.escape_pending) begin
        state_o.flags_busy = 1'b1;
        result_o.status    = ST_BADESC;
      end else begin
        state_o.escape_pending = 1'b1;
      end
    end else if (b == cfg_i.stop_byte) begin
      if (state_i.frame_done || (state_i.byte_count == 8'd0)) begin
        state_o.flags_busy = 1'b1;
        result_o.status    = ST_NOSTART;
      end else begin
        state_o.frame_done = 1'b1;
        state_o.held_valid = 1'b0;
        if ((state_i.ident & cfg_i.id_size_mask) != 8'd0) begin
          // sized packet: last byte is payload, no checksum
          result_o.data_valid    = state_i.held_valid;
          result_o.data_byte     = state_i.held_valid ? state_i.held_byte : 8'd0;
          result_o.status        = ST_DONE;
          result_o.packet_length = state_i.byte_count;
        end else begin
          state_o.byte_count = state_i.byte_count - 8'd1;
          if (state_i.running_sum != state_i.held_byte) begin
            result_o.status = ST_CHKERR;
          end else begin
            result_o.status        = ST_DONE;
            result_o.packet_length = state_i.byte_count - 8'd1;
          end
        end
      end
    end else begin
      if (state_i.frame_done) begin
        state_o.flags_busy = 1'b1;
        result_o.status    = ST_NOSTART;
      end else if (!state_i.escape_pending && !state_i.flags_busy &&
                   !state_i.size_known) begin
        state_o.flags_busy  = 1'b1;
        state_o.ident       = b;
        state_o.running_sum = b;
        result_o.status     = ST_ID;
      end else begin
        state_o.escape_pending = 1'b0;
        result_o.data_valid    = state_i.held_valid;
        result_o.data_byte     = state_i.held_valid ? state_i.held_byte : 8'd0;
        state_o.running_sum    = sum_pushed;
        state_o.held_byte      = decoded;
        state_o.held_valid     = 1'b1;
        state_o.byte_count     = state_i.byte_count + 8'd1;
      end
    end

    result_o.packet_id = state_o.ident;
  end

endmodule

/* src/sfr_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

// port-level checks of the frame receiver
module sfr_checker import sfr_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_o,
  input sfr_in_t  in_data_i,
  input logic     out_valid_o,
  input logic     out_ready_i,
  input sfr_out_t out_data_o
);

  logic in_take;
  logic out_stall;
  logic is_restart;
  logic restart_ok;
  logic has_len;
  logic is_done;
  logic data_status_ok;

  assign in_take        = in_valid_i && in_ready_o;
  assign out_stall      = out_valid_o && !out_ready_i;
  assign is_restart     = in_data_i.command == CMD_RESTART;
  assign restart_ok     = (out_data_o.status == ST_NONE) &&
                          (out_data_o.packet_id == 8'd0) && !out_data_o.data_valid;
  assign has_len        = out_valid_o && (out_data_o.packet_length != 8'd0);
  assign is_done        = out_data_o.status == ST_DONE;
  assign data_status_ok = (out_data_o.status == ST_NONE) || (out_data_o.status == ST_DONE);

  // a stalled result holds
  `SFR_ASSERT_CK(a_out_hold, out_stall |=> out_valid_o && $stable(out_data_o), "result moved")

  // a restart answers with an empty status and a cleared id
  `SFR_ASSERT_CK(a_restart, in_take && is_restart |=> out_valid_o && restart_ok, "bad restart")

  // length only reported with completion
  `SFR_ASSERT_CK(a_len_done, has_len |-> is_done, "length without completion")

  // no payload released with id, size or error status
  `SFR_ASSERT_CK(a_data_status, out_valid_o && out_data_o.data_valid |-> data_status_ok, "bad data")

  // an accepted byte always yields a result next cycle
  `SFR_ASSERT_CK(a_one_result, in_take |=> out_valid_o, "accepted byte produced no result")

endmodule

bind stuffed_frame_receiver_core sfr_checker u_sfr_checker (.*);
